FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clk / rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qme_pkg.sv
// ----------------------------------------------------------------------------
// qme_pkg
// Shared widths, opcodes, result codes and divider link types of the
// queue machine execute unit.
// ----------------------------------------------------------------------------
package qme_pkg;

    localparam int WORD_W    = 16;
    localparam int OP_W      = 5;
    localparam int REG_IDX_W = 5;
    localparam int NUM_REGS  = 26;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CHAR_W    = 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH_IMM  = 5'd0;
    localparam logic [OP_W-1:0] OP_ADD       = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB       = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL       = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV       = 5'd4;
    localparam logic [OP_W-1:0] OP_MOD       = 5'd5;
    localparam logic [OP_W-1:0] OP_POP_REG   = 5'd6;
    localparam logic [OP_W-1:0] OP_PUSH_REG  = 5'd7;
    localparam logic [OP_W-1:0] OP_PRN_NUM_Q = 5'd8;
    localparam logic [OP_W-1:0] OP_PRN_NUM_R = 5'd9;
    localparam logic [OP_W-1:0] OP_PRN_CHR_Q = 5'd10;
    localparam logic [OP_W-1:0] OP_PRN_CHR_R = 5'd11;
    localparam logic [OP_W-1:0] OP_LABEL     = 5'd12;
    localparam logic [OP_W-1:0] OP_JMP       = 5'd13;
    localparam logic [OP_W-1:0] OP_JZ        = 5'd14;
    localparam logic [OP_W-1:0] OP_JEQ       = 5'd15;
    localparam logic [OP_W-1:0] OP_JGT       = 5'd16;
    localparam logic [OP_W-1:0] OP_QUIT      = 5'd17;

    // result kind
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHR  = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/queue_machine_execute_top.sv
// ----------------------------------------------------------------------------
// queue_machine_execute_top
// Execute unit of a 16-bit queue machine: one decoded instruction in, one
// result (print value, branch taken, status) out.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. Plain instructions (push, pop,
// print, jumps, quit) pass the execute and output states; add, sub and mul
// add a second pop state and a push state, since the two operands come out
// of the single read port of the queue memory in two consecutive reads; div
// and mod with a nonzero divisor also wait in a divide state for the
// bit-serial divider. The finished result sits in an output register, so a
// new instruction is taken while it waits for transfer.
// The queue lives in a QUEUE_DEPTH x 16 synchronous RAM; the register file is
// a 26 x 16 RAM with two read ports and per-entry valid bits, so it reads as
// zero after reset with no clearing pass.
module queue_machine_execute_top #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [qme_pkg::OP_W-1:0]      req_type,
    input  logic [qme_pkg::REG_IDX_W-1:0] reg_first,
    input  logic [qme_pkg::REG_IDX_W-1:0] reg_second,
    input  logic [qme_pkg::WORD_W-1:0]    imm_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [qme_pkg::KIND_W-1:0]    out_kind,
    output logic [qme_pkg::WORD_W-1:0]    out_value,
    output logic                          branch_taken,
    output logic [qme_pkg::STATUS_W-1:0]  status
);
    import qme_pkg::*;

`include "assert_macros.svh"

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_POP2 = 6'b000100,
        S_DIV  = 6'b001000,
        S_PUSH = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0]   head_reg, head_next, head_inc;
    logic [PTR_W-1:0]   tail_reg, tail_next, tail_inc;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               halted_reg, halted_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // instruction latched at transfer
    logic [OP_W-1:0]      op_reg, op_next;
    logic [REG_IDX_W-1:0] ra_reg, ra_next;
    logic [WORD_W-1:0]    imm_reg, imm_next;

    logic [WORD_W-1:0]    x_reg, x_next;
    logic [WORD_W-1:0]    r_reg, r_next;
    logic [2*WORD_W-1:0]  product;

    // pending result
    logic [KIND_W-1:0]    res_kind_reg, res_kind_next;
    logic [WORD_W-1:0]    res_value_reg, res_value_next;
    logic                 res_branch_reg, res_branch_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    // output register
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [WORD_W-1:0]    out_value_reg, out_value_next;
    logic                 out_branch_reg, out_branch_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    logic req_fire;
    logic out_free;

    // queue memory
    logic [WORD_W-1:0] q_mem [0:QUEUE_DEPTH-1];
    logic              q_re;
    logic [PTR_W-1:0]  q_raddr;
    logic [WORD_W-1:0] q_rd_reg;
    logic              q_we;
    logic [WORD_W-1:0] q_wdata;

    // register file memory
    logic [WORD_W-1:0]   rf_mem [0:NUM_REGS-1];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [WORD_W-1:0]   rf_a_reg, rf_b_reg;
    logic                ra_ok_reg, rb_ok_reg;
    logic                rf_we;
    logic [WORD_W-1:0]   rf_wdata;
    logic [WORD_W-1:0]   reg_a, reg_b;

    div_req_t div_req;
    div_rsp_t div_rsp;

    qme_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign reg_a   = ra_ok_reg ? rf_a_reg : '0;
    assign reg_b   = rb_ok_reg ? rf_b_reg : '0;
    assign product = x_reg * q_rd_reg;

    // second operand is read at head+1 while the first is consumed
    assign q_re    = req_fire || (state_reg == S_EXEC);
    assign q_raddr = (state_reg == S_EXEC) ? head_inc : head_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        halted_next     = halted_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        ra_next         = ra_reg;
        imm_next        = imm_reg;
        x_next          = x_reg;
        r_next          = r_reg;
        res_kind_next   = res_kind_reg;
        res_value_next  = res_value_reg;
        res_branch_next = res_branch_reg;
        res_status_next = res_status_reg;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_branch_next = out_branch_reg;
        out_status_next = out_status_reg;
        q_we            = 1'b0;
        q_wdata         = r_reg;
        rf_we           = 1'b0;
        rf_wdata        = q_rd_reg;
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = q_rd_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_type;
                    ra_next    = reg_first;
                    imm_next   = imm_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_kind_next   = KIND_NONE;
                res_value_next  = '0;
                res_branch_next = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_OUT;
                if (halted_reg)
                begin
                    res_status_next = ST_HALTED;
                end
                else if (op_reg inside {[OP_ADD:OP_MOD]})
                begin
                    if (count_reg < COUNT_W'(2))
                    begin
                        res_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        x_next     = q_rd_reg;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        state_next = S_POP2;
                    end
                end
                else
                begin
                    case (op_reg)
                        OP_PUSH_IMM, OP_PUSH_REG:
                        begin
                            if (count_reg == COUNT_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                q_we       = 1'b1;
                                q_wdata    = (op_reg == OP_PUSH_IMM) ? imm_reg : reg_a;
                                tail_next  = tail_inc;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_REG, OP_PRN_NUM_Q, OP_PRN_CHR_Q:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                if (op_reg == OP_POP_REG)
                                begin
                                    rf_we = (ra_reg < REG_IDX_W'(NUM_REGS));
                                end
                                else if (op_reg == OP_PRN_NUM_Q)
                                begin
                                    res_kind_next  = KIND_NUM;
                                    res_value_next = q_rd_reg;
                                end
                                else
                                begin
                                    res_kind_next  = KIND_CHR;
                                    res_value_next = {{(WORD_W-CHAR_W){1'b0}},
                                                      q_rd_reg[CHAR_W-1:0]};
                                end
                            end
                        end
                        OP_PRN_NUM_R:
                        begin
                            res_kind_next  = KIND_NUM;
                            res_value_next = reg_a;
                        end
                        OP_PRN_CHR_R:
                        begin
                            res_kind_next  = KIND_CHR;
                            res_value_next = {{(WORD_W-CHAR_W){1'b0}}, reg_a[CHAR_W-1:0]};
                        end
                        OP_JMP:  res_branch_next = 1'b1;
                        OP_JZ:   res_branch_next = (reg_a == '0);
                        OP_JEQ:  res_branch_next = (reg_a == reg_b);
                        OP_JGT:  res_branch_next = (reg_a > reg_b);
                        OP_QUIT:
                        begin
                            halted_next     = 1'b1;
                            res_status_next = ST_HALTED;
                        end
                        OP_LABEL: ;
                        default: ;
                    endcase
                end
            end

            S_POP2:
            begin
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                state_next = S_PUSH;
                case (op_reg)
                    OP_ADD: r_next = x_reg + q_rd_reg;
                    OP_SUB: r_next = x_reg - q_rd_reg;
                    OP_MUL: r_next = product[WORD_W-1:0];
                    default:
                    begin
                        if (q_rd_reg == '0)
                        begin
                            r_next = '0;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    r_next     = (op_reg == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // two words were popped, so this slot is always free
                q_we       = 1'b1;
                tail_next  = tail_inc;
                count_next = count_reg + 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_kind_next   = res_kind_reg;
                    out_value_next  = res_value_reg;
                    out_branch_next = res_branch_reg;
                    out_status_next = res_status_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ra_reg         <= ra_next;
        imm_reg        <= imm_next;
        x_reg          <= x_next;
        r_reg          <= r_next;
        res_kind_reg   <= res_kind_next;
        res_value_reg  <= res_value_next;
        res_branch_reg <= res_branch_next;
        res_status_reg <= res_status_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_branch_reg <= out_branch_next;
        out_status_reg <= out_status_next;
    end

    // queue RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg] <= q_wdata;
        end
        if (q_re)
        begin
            q_rd_reg <= q_mem[q_raddr];
        end
    end

    // register file RAM: one write, two registered reads at transfer
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[ra_reg] <= rf_wdata;
        end
        if (req_fire)
        begin
            rf_a_reg  <= rf_mem[reg_first];
            rf_b_reg  <= rf_mem[reg_second];
            ra_ok_reg <= (reg_first < REG_IDX_W'(NUM_REGS)) && rf_valid_reg[reg_first];
            rb_ok_reg <= (reg_second < REG_IDX_W'(NUM_REGS)) && rf_valid_reg[reg_second];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[ra_reg] <= 1'b1;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_value    = out_value_reg;
    assign branch_taken = out_branch_reg;
    assign status       = out_status_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_W'(QUEUE_DEPTH), "queue count above depth")
    `ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halted flag cleared without reset")
    `ASSERT_IMPL(a_halt_status, (state_reg == S_OUT) && halted_reg, res_status_reg == ST_HALTED, "result of halted machine not flagged halted")
    `ASSERT_IMPL(a_div_nonzero, div_req.start, (div_req.divisor != '0) && (state_reg == S_POP2), "divider started with zero divisor or out of sequence")

endmodule

FILE: rtl/qme_divider.sv
// ----------------------------------------------------------------------------
// qme_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Divisor must be nonzero; done pulses in the cycle after the last bit step.
// ----------------------------------------------------------------------------
module qme_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  qme_pkg::div_req_t  req,
    output qme_pkg::div_rsp_t  rsp
);
    import qme_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
